[hw/rtl/nnact_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnact_pkg
// Shared types, constants and the exp table for the activation unit.
// ----------------------------------------------------------------------------
package nnact_pkg;

  // column buffer and exp table sizing
  localparam int unsigned COLUMN_DEPTH   = 16;
  localparam int unsigned EXP_TABLE_BITS = 10;
  localparam int unsigned EXP_ROM_SIZE   = 1 << EXP_TABLE_BITS;

  // derived widths
  localparam int unsigned CNT_W  = $clog2(COLUMN_DEPTH + 1);
  localparam int unsigned IDX_W  = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
  localparam int unsigned SUM_W  = 31 + $clog2(COLUMN_DEPTH);
  localparam int unsigned DEN_W  = SUM_W + 1;
  localparam int unsigned QUO_W  = 12;
  localparam int unsigned NUM_W  = DEN_W + QUO_W;
  localparam int unsigned DOT_W  = 32 + $clog2(COLUMN_DEPTH);
  localparam int unsigned M1_W   = DOT_W + 1;
  localparam int unsigned M2_W   = M1_W + 16;
  localparam int unsigned T_W    = 17;
  localparam int unsigned P_W    = 34;
  localparam int unsigned SH_W   = P_W - 27;
  localparam int unsigned ROM_W  = 31;

  // fixed-point constants
  localparam logic [T_W-1:0]   LOG2E_Q16       = 17'd94548;
  localparam logic [31:0]      ONE_Q30         = 32'h4000_0000;
  localparam logic [SH_W-1:0]  EXP_SHIFT_LIMIT = SH_W'(40);
  localparam longint unsigned  LN2_Q30         = 64'd744261118;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FUNC_SELECT = 2'd0,
    REG_DIRECTION   = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FUNC_IDENTITY = 3'd0,
    FUNC_SIGMOID  = 3'd1,
    FUNC_TANH     = 3'd2,
    FUNC_RELU     = 3'd3,
    FUNC_SOFTMAX  = 3'd4
  } func_e;

  typedef enum logic {
    DIR_FORWARD  = 1'b0,
    DIR_BACKWARD = 1'b1
  } dir_e;

  // words on the two channels
  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] grad_in;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last_res;
    logic               overflow;
  } out_word_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_STORE,
    OP_READ,
    OP_TLOAD,
    OP_EXP_MUL,
    OP_EXP_ROM,
    OP_EXP_SHIFT,
    OP_SUM_ACC,
    OP_DOT_ACC,
    OP_DIV_START,
    OP_DIV_RES,
    OP_MUL1,
    OP_MUL2,
    OP_ROUND,
    OP_DIRECT,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_STORE,
    S_READ,
    S_TLOAD,
    S_EXP_MUL,
    S_EXP_ROM,
    S_EXP_SHIFT,
    S_SUM_ACC,
    S_DOT_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_DIV_RES,
    S_MUL1,
    S_MUL2,
    S_ROUND,
    S_DIRECT,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_softmax;
    logic exp_fwd;
    logic mul_bwd;
    logic dir_bwd;
    logic last_item;
    logic at_end;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // exp table: 2^-(i/2^B) in Q1.30 from a series through the 14th power
  typedef logic [ROM_W-1:0] exp_rom_t [EXP_ROM_SIZE];

  // long division of a series term by its index, operand below 2^32
  function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 31; b >= 0; b--) begin
      rem = (rem << 1) | longint'(num[b]);
      if (rem >= longint'(den)) begin
        rem    = rem - longint'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        rom;
    longint unsigned y;
    longint unsigned term;
    longint          sum;
    for (int unsigned i = 0; i < EXP_ROM_SIZE; i++) begin
      y    = (longint'(i) * LN2_Q30) >> EXP_TABLE_BITS;
      term = 64'd1 << 30;
      sum  = 64'sd1 << 30;
      for (int unsigned k = 1; k <= 14; k++) begin
        term = div_small((term * y) >> 30, k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      rom[i] = sum[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[hw/rtl/nnact_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnact_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnact_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nnact_pkg::NUM_W-1:0]       num_i,
  input  logic [nnact_pkg::DEN_W-1:0]       den_i,
  output logic                              done_o,
  output logic [nnact_pkg::QUO_W-1:0]       quot_o
);

  localparam int unsigned CNT_BITS = $clog2(nnact_pkg::QUO_W + 1);

  logic [nnact_pkg::NUM_W-1:0] rem_q, rem_d;
  logic [nnact_pkg::NUM_W-1:0] dvs_q, dvs_d;
  logic [nnact_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [CNT_BITS-1:0]         cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  // one trial subtract per cycle
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dvs_d  = nnact_pkg::NUM_W'(den_i) << (nnact_pkg::QUO_W - 1);
      quo_d  = '0;
      cnt_d  = CNT_BITS'(nnact_pkg::QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dvs_q) begin
        rem_d = rem_q - dvs_q;
        quo_d = {quo_q[nnact_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[nnact_pkg::QUO_W-2:0], 1'b0};
      end
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

endmodule

[hw/rtl/nnact_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnact_datapath
// Config registers, column buffer, exp pipe, multipliers, divider and
// output register, stepped by controller commands.
// ----------------------------------------------------------------------------
module nnact_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nnact_pkg::in_word_t                  in_data_i,
  input  logic                                 cfg_valid_i,
  input  logic [nnact_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nnact_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  nnact_pkg::ctrl_cmd_t                 cmd_i,
  output nnact_pkg::dp_status_t                status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output nnact_pkg::out_word_t                 out_data_o
);

  localparam int unsigned CNT_W = nnact_pkg::CNT_W;
  localparam int unsigned IDX_W = nnact_pkg::IDX_W;
  localparam int unsigned M1_W  = nnact_pkg::M1_W;
  localparam int unsigned M2_W  = nnact_pkg::M2_W;

  // config and column control
  logic [2:0]              func_q;
  logic                    dir_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [15:0]      max_q;
  logic                    dropped_q;
  logic                    out_valid_q;

  // operands and pipeline
  logic signed [15:0]              a_q, b_q;
  logic                            last_q;
  logic [nnact_pkg::T_W-1:0]       t_q, t_d;
  logic [nnact_pkg::P_W-1:0]       p_q;
  logic [nnact_pkg::ROM_W-1:0]     rom_q, e_q;
  logic [nnact_pkg::SH_W-1:0]      sh_q;
  logic [nnact_pkg::SUM_W-1:0]     sum_q;
  logic signed [nnact_pkg::DOT_W-1:0] dot_q;
  logic signed [M1_W-1:0]          m1_q, m1_d;
  logic signed [M2_W-1:0]          m2_q;
  logic signed [15:0]              res_q, res_d;
  nnact_pkg::out_word_t            out_q, out_d;

  // column buffer
  logic signed [15:0] val_mem  [nnact_pkg::COLUMN_DEPTH];
  logic signed [15:0] grad_mem [nnact_pkg::COLUMN_DEPTH];

  logic is_softmax, is_sigmoid, is_tanh, is_relu;
  logic at_end, room, out_free, emit_fire, cfg_clear;

  assign is_softmax = (func_q == nnact_pkg::FUNC_SOFTMAX);
  assign is_sigmoid = (func_q == nnact_pkg::FUNC_SIGMOID);
  assign is_tanh    = (func_q == nnact_pkg::FUNC_TANH);
  assign is_relu    = (func_q == nnact_pkg::FUNC_RELU);
  assign at_end     = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
  assign room       = (count_q < CNT_W'(nnact_pkg::COLUMN_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (cmd_i.op == nnact_pkg::OP_EMIT) && out_free;
  assign cfg_clear  = cfg_valid_i &&
                      (cfg_index_i == nnact_pkg::REG_FUNC_SELECT ||
                       cfg_index_i == nnact_pkg::REG_DIRECTION);

  // exp argument
  logic signed [16:0] a_ext, max_ext;
  logic [16:0]        a_mag;
  assign a_ext   = {a_q[15], a_q};
  assign max_ext = {max_q[15], max_q};
  assign a_mag   = a_ext[16] ? 17'(-a_ext) : 17'(a_ext);

  always_comb begin
    priority if (is_softmax) begin
      t_d = 17'(max_ext - a_ext);
    end else if (is_tanh) begin
      t_d = {a_mag[15:0], 1'b0};
    end else begin
      t_d = a_mag;
    end
  end

  // divider operands
  logic [nnact_pkg::DEN_W-1:0] div_den;
  logic [nnact_pkg::NUM_W-1:0] div_num;
  logic [nnact_pkg::QUO_W-1:0] div_quot;
  logic                        div_done;

  always_comb begin
    priority if (is_softmax) begin
      div_den = (sum_q == '0) ? nnact_pkg::DEN_W'(1) : nnact_pkg::DEN_W'(sum_q);
      div_num = (nnact_pkg::NUM_W'(e_q) << 11) + nnact_pkg::NUM_W'(div_den >> 1);
    end else if (is_tanh) begin
      div_den = nnact_pkg::DEN_W'(nnact_pkg::ONE_Q30) + nnact_pkg::DEN_W'(e_q);
      div_num = (nnact_pkg::NUM_W'(nnact_pkg::ONE_Q30 - {1'b0, e_q}) << 11) +
                nnact_pkg::NUM_W'(div_den >> 1);
    end else begin
      div_den = nnact_pkg::DEN_W'(nnact_pkg::ONE_Q30) + nnact_pkg::DEN_W'(e_q);
      div_num = (nnact_pkg::NUM_W'(1) << 41) + nnact_pkg::NUM_W'(div_den >> 1);
    end
  end

  nnact_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == nnact_pkg::OP_DIV_START),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // first product of the backward path
  logic signed [16:0] one_minus;
  logic signed [32:0] sig_prod;
  logic signed [31:0] sq_prod;
  logic signed [31:0] ab_prod;
  logic signed [15:0] mul_b;
  assign one_minus = 17'sd2048 - a_ext;
  assign sig_prod  = a_ext * one_minus;
  assign sq_prod   = a_q * a_q;
  assign ab_prod   = a_q * b_q;
  assign mul_b     = is_softmax ? a_q : b_q;

  always_comb begin
    priority if (is_softmax) begin
      m1_d = (M1_W'(b_q) <<< 11) - M1_W'(dot_q);
    end else if (is_tanh) begin
      m1_d = M1_W'(32'sd4194304) - M1_W'(sq_prod);
    end else begin
      m1_d = M1_W'(sig_prod);
    end
  end

  // round half away from zero by 2^22, then saturate
  logic              m2_neg;
  logic [M2_W-1:0]   m2_abs, rnd_mag;
  logic signed [15:0] rnd_res;
  assign m2_neg  = m2_q[M2_W-1];
  assign m2_abs  = m2_neg ? M2_W'(-m2_q) : M2_W'(m2_q);
  assign rnd_mag = (m2_abs + (M2_W'(1) << 21)) >> 22;

  always_comb begin
    if (!m2_neg) begin
      rnd_res = (rnd_mag > M2_W'(32767)) ? 16'sh7fff : $signed(rnd_mag[15:0]);
    end else begin
      rnd_res = (rnd_mag > M2_W'(32768)) ? 16'sh8000 : $signed(-rnd_mag[15:0]);
    end
  end

  // result select
  logic signed [15:0] q_ext;
  assign q_ext = $signed(16'(div_quot));

  always_comb begin
    res_d = res_q;
    unique case (cmd_i.op)
      nnact_pkg::OP_DIV_RES: begin
        priority if (is_softmax) begin
          res_d = q_ext;
        end else if (is_tanh) begin
          res_d = a_q[15] ? -q_ext : q_ext;
        end else begin
          res_d = a_q[15] ? 16'sd2048 - q_ext : q_ext;
        end
      end
      nnact_pkg::OP_ROUND: res_d = rnd_res;
      nnact_pkg::OP_DIRECT: begin
        if (is_relu) begin
          if (a_q > 16'sd0) begin
            res_d = dir_q ? b_q : a_q;
          end else begin
            res_d = '0;
          end
        end else begin
          res_d = dir_q ? b_q : a_q;
        end
      end
      default: res_d = res_q;
    endcase
  end

  // output word
  always_comb begin
    out_d.value    = res_q;
    out_d.last_res = is_softmax ? at_end : last_q;
    out_d.overflow = is_softmax ? dropped_q : 1'b0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q      <= nnact_pkg::FUNC_IDENTITY;
      dir_q       <= nnact_pkg::DIR_FORWARD;
      count_q     <= '0;
      idx_q       <= '0;
      max_q       <= 16'sh8000;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_clear) begin
        if (cfg_index_i == nnact_pkg::REG_FUNC_SELECT) begin
          func_q <= cfg_data_i;
        end else begin
          dir_q <= cfg_data_i[0];
        end
        count_q   <= '0;
        idx_q     <= '0;
        max_q     <= 16'sh8000;
        dropped_q <= 1'b0;
      end else begin
        unique case (cmd_i.op)
          nnact_pkg::OP_STORE: begin
            if (room) begin
              count_q <= count_q + CNT_W'(1);
              if (a_q > max_q) begin
                max_q <= a_q;
              end
            end else begin
              dropped_q <= 1'b1;
            end
          end
          nnact_pkg::OP_SUM_ACC, nnact_pkg::OP_DOT_ACC: begin
            idx_q <= at_end ? '0 : idx_q + IDX_W'(1);
          end
          nnact_pkg::OP_EMIT: begin
            if (emit_fire && is_softmax) begin
              if (at_end) begin
                idx_q     <= '0;
                count_q   <= '0;
                max_q     <= 16'sh8000;
                dropped_q <= 1'b0;
              end else begin
                idx_q <= idx_q + IDX_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // operand and pipeline registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (emit_fire) begin
      out_q <= out_d;
    end
    unique case (cmd_i.op)
      nnact_pkg::OP_LOAD: begin
        a_q    <= in_data_i.sample;
        b_q    <= in_data_i.grad_in;
        last_q <= in_data_i.last;
      end
      nnact_pkg::OP_STORE: begin
        sum_q <= '0;
        dot_q <= '0;
      end
      nnact_pkg::OP_READ: begin
        a_q <= val_mem[idx_q];
        b_q <= grad_mem[idx_q];
      end
      nnact_pkg::OP_TLOAD:    t_q <= t_d;
      nnact_pkg::OP_EXP_MUL:  p_q <= nnact_pkg::P_W'(t_q) * nnact_pkg::P_W'(nnact_pkg::LOG2E_Q16);
      nnact_pkg::OP_EXP_ROM: begin
        rom_q <= nnact_pkg::EXP_ROM[p_q[26 -: nnact_pkg::EXP_TABLE_BITS]];
        sh_q  <= p_q[nnact_pkg::P_W-1:27];
      end
      nnact_pkg::OP_EXP_SHIFT: begin
        e_q <= (sh_q >= nnact_pkg::EXP_SHIFT_LIMIT) ? '0 : rom_q >> sh_q;
      end
      nnact_pkg::OP_SUM_ACC: sum_q <= sum_q + nnact_pkg::SUM_W'(e_q);
      nnact_pkg::OP_DOT_ACC: dot_q <= dot_q + nnact_pkg::DOT_W'(ab_prod);
      nnact_pkg::OP_MUL1:    m1_q <= m1_d;
      nnact_pkg::OP_MUL2:    m2_q <= m1_q * mul_b;
      default: ;
    endcase
  end

  // column buffer write
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == nnact_pkg::OP_STORE && room) begin
      val_mem[count_q[IDX_W-1:0]]  <= a_q;
      grad_mem[count_q[IDX_W-1:0]] <= b_q;
    end
  end

  always_comb begin
    status_o.is_softmax = is_softmax;
    status_o.exp_fwd    = !dir_q && (is_sigmoid || is_tanh);
    status_o.mul_bwd    = dir_q && (is_sigmoid || is_tanh);
    status_o.dir_bwd    = dir_q;
    status_o.last_item  = last_q;
    status_o.at_end     = at_end;
    status_o.div_done   = div_done;
    status_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> count_q == CNT_W'(nnact_pkg::COLUMN_DEPTH))
    else $error("elements dropped before the column filled");

  a_idx_in_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> CNT_W'(idx_q) < count_q)
    else $error("column index beyond element count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result word changed");

endmodule

[hw/rtl/nnact_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnact_ctrl
// Sequencer: steps the datapath through one element or one column pass.
// ----------------------------------------------------------------------------
module nnact_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  nnact_pkg::dp_status_t  status_i,
  output nnact_pkg::ctrl_cmd_t   cmd_o
);

  nnact_pkg::ctrl_state_e state_q, state_d;
  logic                   pass_q, pass_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nnact_pkg::S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o.op   = nnact_pkg::OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      nnact_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = nnact_pkg::OP_LOAD;
          state_d  = nnact_pkg::S_DISPATCH;
        end
      end
      nnact_pkg::S_DISPATCH: begin
        priority if (status_i.is_softmax) begin
          state_d = nnact_pkg::S_STORE;
        end else if (status_i.exp_fwd) begin
          state_d = nnact_pkg::S_TLOAD;
        end else if (status_i.mul_bwd) begin
          state_d = nnact_pkg::S_MUL1;
        end else begin
          state_d = nnact_pkg::S_DIRECT;
        end
      end
      nnact_pkg::S_STORE: begin
        cmd_o.op = nnact_pkg::OP_STORE;
        pass_d   = 1'b0;
        state_d  = status_i.last_item ? nnact_pkg::S_READ : nnact_pkg::S_IDLE;
      end
      nnact_pkg::S_READ: begin
        cmd_o.op = nnact_pkg::OP_READ;
        priority if (!status_i.dir_bwd) begin
          state_d = nnact_pkg::S_TLOAD;
        end else if (!pass_q) begin
          state_d = nnact_pkg::S_DOT_ACC;
        end else begin
          state_d = nnact_pkg::S_MUL1;
        end
      end
      nnact_pkg::S_TLOAD: begin
        cmd_o.op = nnact_pkg::OP_TLOAD;
        state_d  = nnact_pkg::S_EXP_MUL;
      end
      nnact_pkg::S_EXP_MUL: begin
        cmd_o.op = nnact_pkg::OP_EXP_MUL;
        state_d  = nnact_pkg::S_EXP_ROM;
      end
      nnact_pkg::S_EXP_ROM: begin
        cmd_o.op = nnact_pkg::OP_EXP_ROM;
        state_d  = nnact_pkg::S_EXP_SHIFT;
      end
      nnact_pkg::S_EXP_SHIFT: begin
        cmd_o.op = nnact_pkg::OP_EXP_SHIFT;
        state_d  = (status_i.is_softmax && !pass_q) ? nnact_pkg::S_SUM_ACC
                                                    : nnact_pkg::S_DIV_START;
      end
      nnact_pkg::S_SUM_ACC: begin
        cmd_o.op = nnact_pkg::OP_SUM_ACC;
        if (status_i.at_end) begin
          pass_d = 1'b1;
        end
        state_d = nnact_pkg::S_READ;
      end
      nnact_pkg::S_DOT_ACC: begin
        cmd_o.op = nnact_pkg::OP_DOT_ACC;
        if (status_i.at_end) begin
          pass_d = 1'b1;
        end
        state_d = nnact_pkg::S_READ;
      end
      nnact_pkg::S_DIV_START: begin
        cmd_o.op = nnact_pkg::OP_DIV_START;
        state_d  = nnact_pkg::S_DIV_WAIT;
      end
      nnact_pkg::S_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = nnact_pkg::S_DIV_RES;
        end
      end
      nnact_pkg::S_DIV_RES: begin
        cmd_o.op = nnact_pkg::OP_DIV_RES;
        state_d  = nnact_pkg::S_EMIT;
      end
      nnact_pkg::S_MUL1: begin
        cmd_o.op = nnact_pkg::OP_MUL1;
        state_d  = nnact_pkg::S_MUL2;
      end
      nnact_pkg::S_MUL2: begin
        cmd_o.op = nnact_pkg::OP_MUL2;
        state_d  = nnact_pkg::S_ROUND;
      end
      nnact_pkg::S_ROUND: begin
        cmd_o.op = nnact_pkg::OP_ROUND;
        state_d  = nnact_pkg::S_EMIT;
      end
      nnact_pkg::S_DIRECT: begin
        cmd_o.op = nnact_pkg::OP_DIRECT;
        state_d  = nnact_pkg::S_EMIT;
      end
      nnact_pkg::S_EMIT: begin
        cmd_o.op = nnact_pkg::OP_EMIT;
        if (status_i.out_free) begin
          state_d = (status_i.is_softmax && !status_i.at_end) ? nnact_pkg::S_READ
                                                              : nnact_pkg::S_IDLE;
        end
      end
      default: state_d = nnact_pkg::S_IDLE;
    endcase
  end

endmodule

[hw/rtl/nn_activation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nn_activation_unit
// Q4.11 activation unit: identity, sigmoid, tanh, relu, softmax, forward
// and backward, with a table-based exp and a bit-serial divider.
// ----------------------------------------------------------------------------
// Each accepted word is stepped through before another word is taken:
//   identity / relu: dispatch, direct result, emit; sigmoid / tanh backward:
//   two multiplies, rounding, emit; sigmoid / tanh forward: exp pipe, divider
//   wait, emit; softmax: each element buffered; at the column end a sum pass
//   and then one pass per element out (backward: a dot pass, then multiplies)
// Reset: identity, forward, column empty; the column buffer needs no clearing.
module nn_activation_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  nnact_pkg::in_word_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output nnact_pkg::out_word_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nnact_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nnact_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  nnact_pkg::ctrl_cmd_t  cmd;
  nnact_pkg::dp_status_t status;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  nnact_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nnact_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
